// File: rtl/ecsm_pkg.sv
// ecsm_pkg: shared types, constants and codes for the scalar multiply unit
// no dependencies
package ecsm_pkg;

    localparam int FIELD_BITS  = 16;
    localparam int SCALAR_BITS = 16;
    localparam int PROD_BITS   = 2 * FIELD_BITS;
    localparam int SCNT_BITS   = $clog2(SCALAR_BITS + 1);
    localparam int RCNT_BITS   = $clog2(PROD_BITS + 1);

    localparam logic [FIELD_BITS-1:0] PRIME_RESET = FIELD_BITS'(23);
    localparam logic [FIELD_BITS-1:0] COEFF_RESET = FIELD_BITS'(1);

    // configuration register indexes
    localparam logic [0:0] REG_PRIME = 1'b0;
    localparam logic [0:0] REG_COEFF = 1'b1;

    // arithmetic unit operations
    typedef enum logic [2:0] {
        OP_MUL,
        OP_ADD,
        OP_SUB,
        OP_RED,
        OP_INV
    } alu_op_t;

    typedef struct packed {
        logic                  start;
        alu_op_t               op;
        logic [FIELD_BITS-1:0] opa;
        logic [FIELD_BITS-1:0] opb;
        logic [FIELD_BITS-1:0] modulus;
    } alu_req_t;

    typedef struct packed {
        logic                  done;
        logic [FIELD_BITS-1:0] value;
        logic                  fail;
    } alu_rsp_t;

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE,
        S_RED_X, S_RED_Y, S_RED_A,
        S_BIT,
        S_ADD_CHK,
        S_ADD_NUM, S_ADD_DEN,
        S_DBL_CHK,
        S_DBL_SQ, S_DBL_SQ3, S_DBL_NUM, S_DBL_DEN,
        S_INV, S_LAM,
        S_LSQ, S_RX1, S_RX2, S_DX, S_LDX, S_RY,
        S_NEXT,
        S_DONE
    } seq_state_t;

endpackage

// File: rtl/ec_scalar_multiply_gfp_unit.sv
// throughput: one item at a time; in_stall is high from acceptance until the
// result beat is taken; the shared modular unit sets the rate
// reset: rst_n asynchronous active low; prime 23, coefficient 1, no result held
// top level of the scalar multiply unit; depends on ecsm_pkg, ecsm_alu, ecsm_seq
module ec_scalar_multiply_gfp_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] scalar,
    input  logic [15:0] point_x,
    input  logic [15:0] point_y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] result_x,
    output logic [15:0] result_y,
    output logic        result_is_infinity,
    output logic        inverse_failed,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int W = ecsm_pkg::FIELD_BITS;

    logic [W-1:0]       prime_reg, coeff_reg;
    logic               busy_reg, busy_next;
    logic               ov_reg, ov_next;
    logic [15:0]        rx_reg, ry_reg;
    logic               rinf_reg, rfail_reg;
    ecsm_pkg::alu_req_t req;
    ecsm_pkg::alu_rsp_t rsp;
    logic               sdone;
    logic [15:0]        sx, sy;
    logic               sinf, sfail;
    logic               accept;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = busy_reg;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_reg <= ecsm_pkg::PRIME_RESET;
            coeff_reg <= ecsm_pkg::COEFF_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == ecsm_pkg::REG_PRIME)
                prime_reg <= W'(cfg_data);
            else
                coeff_reg <= W'(cfg_data);
        end
    end

    // busy from accept until the result beat leaves
    always_comb
    begin
        busy_next = busy_reg;
        ov_next   = ov_reg;
        if (accept)
            busy_next = 1'b1;
        if (sdone)
            ov_next = 1'b1;
        if (ov_reg && !out_stall)
        begin
            ov_next   = 1'b0;
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (sdone)
        begin
            rx_reg    <= sx;
            ry_reg    <= sy;
            rinf_reg  <= sinf;
            rfail_reg <= sfail;
        end
    end

    ecsm_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .scalar   (scalar),
        .point_x  (point_x),
        .point_y  (point_y),
        .prime    (prime_reg),
        .coeff    (coeff_reg),
        .req      (req),
        .rsp      (rsp),
        .done     (sdone),
        .res_x    (sx),
        .res_y    (sy),
        .res_inf  (sinf),
        .res_fail (sfail)
    );

    ecsm_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign out_valid          = ov_reg;
    assign result_x           = rx_reg;
    assign result_y           = ry_reg;
    assign result_is_infinity = rinf_reg;
    assign inverse_failed     = rfail_reg;

endmodule

// File: rtl/ecsm_alu.sv
// ecsm_alu: shared multi-cycle modular unit (multiply, add, sub, reduce, inverse)
// depends on ecsm_pkg
module ecsm_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  ecsm_pkg::alu_req_t req,
    output ecsm_pkg::alu_rsp_t rsp
);

    localparam int W  = ecsm_pkg::FIELD_BITS;
    localparam int PW = ecsm_pkg::PROD_BITS;

    typedef enum logic [2:0] {
        A_IDLE, A_MUL, A_RED, A_DIV, A_UPD, A_FIN
    } alu_state_t;

    alu_state_t                       state_reg, state_next;
    ecsm_pkg::alu_op_t                op_reg, op_next;
    logic [PW-1:0]                    acc_reg, acc_next;      // product / dividend
    logic [W:0]                       rem_reg, rem_next;      // running remainder
    logic [W-1:0]                     mul_reg, mul_next;      // multiplier bits
    logic [W-1:0]                     mod_reg, mod_next;
    logic [ecsm_pkg::RCNT_BITS-1:0]   cnt_reg, cnt_next;
    // euclid state
    logic [W-1:0]                     r_reg, r_next, nr_reg, nr_next;
    logic [W-1:0]                     q_reg, q_next;
    logic signed [W+1:0]              t_reg, t_next, nt_reg, nt_next;
    logic [W:0]                       dden_reg, dden_next;
    logic [W-1:0]                     res_reg, res_next;
    logic                             fail_reg, fail_next;
    logic                             done_reg, done_next;

    logic [W+1:0]                     sum;
    logic [W:0]                       trial;
    logic [PW-1:0]                    dbl;
    logic signed [PW+3:0]             qnt;

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        mul_reg  <= mul_next;
        mod_reg  <= mod_next;
        cnt_reg  <= cnt_next;
        r_reg    <= r_next;
        nr_reg   <= nr_next;
        q_reg    <= q_next;
        t_reg    <= t_next;
        nt_reg   <= nt_next;
        dden_reg <= dden_next;
        res_reg  <= res_next;
        fail_reg <= fail_next;
    end

    // one step of the shared datapath per cycle
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        mul_next   = mul_reg;
        mod_next   = mod_reg;
        cnt_next   = cnt_reg;
        r_next     = r_reg;
        nr_next    = nr_reg;
        q_next     = q_reg;
        t_next     = t_reg;
        nt_next    = nt_reg;
        dden_next  = dden_reg;
        res_next   = res_reg;
        fail_next  = fail_reg;
        done_next  = 1'b0;
        sum        = '0;
        trial      = '0;
        dbl        = '0;
        qnt        = '0;
        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    op_next   = req.op;
                    mod_next  = req.modulus;
                    fail_next = 1'b0;
                    rem_next  = '0;
                    cnt_next  = ecsm_pkg::RCNT_BITS'(PW);
                    unique case (req.op)
                        ecsm_pkg::OP_MUL:
                        begin
                            acc_next   = '0;
                            mul_next   = req.opb;
                            dden_next  = {1'b0, req.opa};
                            cnt_next   = ecsm_pkg::RCNT_BITS'(W);
                            state_next = A_MUL;
                        end
                        ecsm_pkg::OP_ADD:
                        begin
                            acc_next   = PW'({1'b0, req.opa} + {1'b0, req.opb});
                            state_next = A_RED;
                        end
                        ecsm_pkg::OP_SUB:
                        begin
                            acc_next   = PW'({2'b0, req.opa} + {2'b0, req.modulus}
                                             - {2'b0, req.opb});
                            state_next = A_RED;
                        end
                        ecsm_pkg::OP_RED:
                        begin
                            acc_next   = PW'(req.opa);
                            state_next = A_RED;
                        end
                        default:
                        begin
                            // inverse: r = m, nr = v
                            r_next     = req.modulus;
                            nr_next    = req.opa;
                            t_next     = '0;
                            nt_next    = (W+2)'(1);
                            state_next = A_DIV;
                            acc_next   = PW'(req.modulus);
                            dden_next  = {1'b0, req.opa};
                            q_next     = '0;
                            cnt_next   = ecsm_pkg::RCNT_BITS'(W);
                            if (req.opa == '0)
                                state_next = A_FIN;
                        end
                    endcase
                end
            end
            A_MUL:
            begin
                // shift-add, msb first
                dbl = {acc_reg[PW-2:0], 1'b0};
                if (mul_reg[W-1])
                    dbl = dbl + PW'(dden_reg);
                acc_next = dbl;
                mul_next = {mul_reg[W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == ecsm_pkg::RCNT_BITS'(1))
                begin
                    rem_next   = '0;
                    cnt_next   = ecsm_pkg::RCNT_BITS'(PW);
                    state_next = A_RED;
                end
            end
            A_RED:
            begin
                // restoring reduction, one bit per cycle
                sum   = {rem_reg, acc_reg[PW-1]};
                trial = (W+1)'(sum - {2'b0, mod_reg});
                if (sum >= {2'b0, mod_reg})
                    rem_next = trial;
                else
                    rem_next = sum[W:0];
                acc_next = {acc_reg[PW-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == ecsm_pkg::RCNT_BITS'(1))
                begin
                    res_next   = W'(rem_next);
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
            end
            A_DIV:
            begin
                // restoring divide r / nr, one quotient bit per cycle
                sum   = {rem_reg, acc_reg[W-1]};
                trial = (W+1)'(sum - {1'b0, dden_reg});
                q_next = {q_reg[W-2:0], 1'b0};
                if (sum >= {1'b0, dden_reg})
                begin
                    rem_next  = trial;
                    q_next[0] = 1'b1;
                end
                else
                    rem_next = sum[W:0];
                acc_next = {acc_reg[PW-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == ecsm_pkg::RCNT_BITS'(1))
                    state_next = A_UPD;
            end
            A_UPD:
            begin
                qnt     = (PW+4)'(t_reg) - $signed({4'b0, q_reg}) * (PW+4)'(nt_reg);
                t_next  = nt_reg;
                nt_next = (W+2)'(qnt);
                r_next  = nr_reg;
                nr_next = W'(rem_reg);
                if (rem_reg == '0)
                    state_next = A_FIN;
                else
                begin
                    acc_next  = PW'(nr_reg);
                    dden_next = rem_reg;
                    rem_next  = '0;
                    q_next    = '0;
                    cnt_next  = ecsm_pkg::RCNT_BITS'(W);
                    state_next = A_DIV;
                end
            end
            default:
            begin
                // A_FIN: check gcd and fold t into range
                if (r_reg != W'(1))
                begin
                    fail_next = 1'b1;
                    res_next  = '0;
                end
                else if (t_reg < 0)
                    res_next = W'(t_reg + (W+2)'(mod_reg));
                else
                    res_next = W'(t_reg);
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
        endcase
    end

    assign rsp.done  = done_reg;
    assign rsp.value = res_reg;
    assign rsp.fail  = fail_reg;

endmodule

// File: rtl/ecsm_seq.sv
// ecsm_seq: double-and-add sequencer driving the shared modular unit
// depends on ecsm_pkg
module ecsm_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [15:0]                   scalar,
    input  logic [15:0]                   point_x,
    input  logic [15:0]                   point_y,
    input  logic [ecsm_pkg::FIELD_BITS-1:0] prime,
    input  logic [ecsm_pkg::FIELD_BITS-1:0] coeff,
    output ecsm_pkg::alu_req_t            req,
    input  ecsm_pkg::alu_rsp_t            rsp,
    output logic                          done,
    output logic [15:0]                   res_x,
    output logic [15:0]                   res_y,
    output logic                          res_inf,
    output logic                          res_fail
);

    localparam int W = ecsm_pkg::FIELD_BITS;
    localparam int S = ecsm_pkg::SCALAR_BITS;

    ecsm_pkg::seq_state_t state_reg, state_next, ret_reg, ret_next;
    logic                 busy_reg, busy_next;
    logic [S-1:0]         k_reg, k_next;
    logic [W-1:0]         bx_reg, bx_next, by_reg, by_next;
    logic [W-1:0]         ax_reg, ax_next, ay_reg, ay_next;
    logic                 ainf_reg, ainf_next;
    logic [W-1:0]         ca_reg, ca_next;
    logic [W-1:0]         num_reg, num_next, tmp_reg, tmp_next, lam_reg, lam_next;
    logic [W-1:0]         px_reg, px_next, py_reg, py_next;  // left operand
    logic [W-1:0]         qx_reg, qx_next;                   // right operand x
    logic [W-1:0]         nx_reg, nx_next;
    logic                 dbl_reg, dbl_next;                 // current op is doubling
    logic                 fail_reg, fail_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ecsm_pkg::S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg  <= ret_next;
        k_reg    <= k_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        ainf_reg <= ainf_next;
        ca_reg   <= ca_next;
        num_reg  <= num_next;
        tmp_reg  <= tmp_next;
        lam_reg  <= lam_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        qx_reg   <= qx_next;
        nx_reg   <= nx_next;
        dbl_reg  <= dbl_next;
        fail_reg <= fail_next;
    end

    // issue strobe: high while a unit request is issued from the current state
    logic issue;

    // next state and datapath updates
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        busy_next  = busy_reg;
        k_next     = k_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        ainf_next  = ainf_reg;
        ca_next    = ca_reg;
        num_next   = num_reg;
        tmp_next   = tmp_reg;
        lam_next   = lam_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        qx_next    = qx_reg;
        nx_next    = nx_reg;
        dbl_next   = dbl_reg;
        fail_next  = fail_reg;
        issue      = 1'b0;
        if (state_reg == ecsm_pkg::S_IDLE)
        begin
            if (start)
            begin
                k_next    = S'(scalar);
                bx_next   = W'(point_x);
                by_next   = W'(point_y);
                ca_next   = coeff;
                ainf_next = 1'b1;
                ax_next   = '0;
                ay_next   = '0;
                fail_next = 1'b0;
                busy_next = 1'b0;
                if (prime < W'(3))
                begin
                    fail_next  = 1'b1;
                    state_next = ecsm_pkg::S_DONE;
                end
                else
                    state_next = ecsm_pkg::S_RED_X;
            end
        end
        else if (state_reg == ecsm_pkg::S_DONE)
            state_next = ecsm_pkg::S_IDLE;
        else if (busy_reg)
        begin
            // waiting on the shared unit
            if (rsp.done)
            begin
                busy_next = 1'b0;
                unique case (state_reg)
                    ecsm_pkg::S_RED_X:   begin bx_next = rsp.value;
                                               state_next = ecsm_pkg::S_RED_Y; end
                    ecsm_pkg::S_RED_Y:   begin by_next = rsp.value;
                                               state_next = ecsm_pkg::S_RED_A; end
                    ecsm_pkg::S_RED_A:   begin ca_next = rsp.value;
                                               state_next = ecsm_pkg::S_BIT; end
                    ecsm_pkg::S_ADD_NUM: begin num_next = rsp.value;
                                               state_next = ecsm_pkg::S_ADD_DEN; end
                    ecsm_pkg::S_ADD_DEN: begin tmp_next = rsp.value;
                                               state_next = ecsm_pkg::S_INV; end
                    ecsm_pkg::S_DBL_SQ:  begin tmp_next = rsp.value;
                                               state_next = ecsm_pkg::S_DBL_SQ3; end
                    ecsm_pkg::S_DBL_SQ3: begin tmp_next = rsp.value;
                                               state_next = ecsm_pkg::S_DBL_NUM; end
                    ecsm_pkg::S_DBL_NUM: begin num_next = rsp.value;
                                               state_next = ecsm_pkg::S_DBL_DEN; end
                    ecsm_pkg::S_DBL_DEN: begin tmp_next = rsp.value;
                                               state_next = ecsm_pkg::S_INV; end
                    ecsm_pkg::S_INV:
                    begin
                        tmp_next = rsp.value;
                        if (rsp.fail)
                        begin
                            fail_next  = 1'b1;
                            state_next = ecsm_pkg::S_DONE;
                        end
                        else
                            state_next = ecsm_pkg::S_LAM;
                    end
                    ecsm_pkg::S_LAM:     begin lam_next = rsp.value;
                                               state_next = ecsm_pkg::S_LSQ; end
                    ecsm_pkg::S_LSQ:     begin tmp_next = rsp.value;
                                               state_next = ecsm_pkg::S_RX1; end
                    ecsm_pkg::S_RX1:     begin tmp_next = rsp.value;
                                               state_next = ecsm_pkg::S_RX2; end
                    ecsm_pkg::S_RX2:     begin nx_next = rsp.value;
                                               state_next = ecsm_pkg::S_DX; end
                    ecsm_pkg::S_DX:      begin tmp_next = rsp.value;
                                               state_next = ecsm_pkg::S_LDX; end
                    ecsm_pkg::S_LDX:     begin tmp_next = rsp.value;
                                               state_next = ecsm_pkg::S_RY; end
                    default:
                    begin
                        // S_RY: write back the new point
                        if (dbl_reg)
                        begin
                            bx_next = nx_reg;
                            by_next = rsp.value;
                        end
                        else
                        begin
                            ax_next   = nx_reg;
                            ay_next   = rsp.value;
                            ainf_next = 1'b0;
                        end
                        state_next = ret_reg;
                    end
                endcase
            end
        end
        else
        begin
            unique case (state_reg)
                ecsm_pkg::S_BIT:
                begin
                    dbl_next = 1'b0;
                    ret_next = ecsm_pkg::S_NEXT;
                    if (k_reg[0])
                        state_next = ecsm_pkg::S_ADD_CHK;
                    else
                        state_next = ecsm_pkg::S_NEXT;
                end
                ecsm_pkg::S_ADD_CHK:
                begin
                    // acc + base
                    px_next = ax_reg;
                    py_next = ay_reg;
                    qx_next = bx_reg;
                    if (ainf_reg)
                    begin
                        ax_next    = bx_reg;
                        ay_next    = by_reg;
                        ainf_next  = 1'b0;
                        state_next = ecsm_pkg::S_NEXT;
                    end
                    else if (ax_reg == bx_reg)
                    begin
                        if (ay_reg != by_reg || ay_reg == '0)
                        begin
                            ainf_next  = 1'b1;
                            ax_next    = '0;
                            ay_next    = '0;
                            state_next = ecsm_pkg::S_NEXT;
                        end
                        else
                            state_next = ecsm_pkg::S_DBL_SQ;
                    end
                    else
                        state_next = ecsm_pkg::S_ADD_NUM;
                end
                ecsm_pkg::S_NEXT:
                begin
                    if (k_reg[S-1:1] == '0 || dbl_reg)
                    begin
                        if (dbl_reg)
                        begin
                            k_next     = k_reg >> 1;
                            state_next = ecsm_pkg::S_BIT;
                        end
                        else
                            state_next = ecsm_pkg::S_DONE;
                    end
                    else
                    begin
                        // base doubling; return here, then shift
                        dbl_next = 1'b1;
                        px_next  = bx_reg;
                        py_next  = by_reg;
                        qx_next  = bx_reg;
                        if (by_reg == '0)
                        begin
                            // doubling to infinity: no further additions change acc
                            // only if later bits are set would it matter; base
                            // infinity adds nothing
                            k_next     = '0;
                            state_next = ecsm_pkg::S_DONE;
                        end
                        else
                            state_next = ecsm_pkg::S_DBL_SQ;
                    end
                end
                default:
                begin
                    // issue a unit operation for the current state
                    issue     = 1'b1;
                    busy_next = 1'b1;
                end
            endcase
        end
    end

    // unit request for the current state
    always_comb
    begin
        req.start   = issue;
        req.modulus = prime;
        req.op      = ecsm_pkg::OP_MUL;
        req.opa     = '0;
        req.opb     = '0;
        unique case (state_reg)
            ecsm_pkg::S_RED_X:   begin req.op = ecsm_pkg::OP_RED; req.opa = bx_reg; end
            ecsm_pkg::S_RED_Y:   begin req.op = ecsm_pkg::OP_RED; req.opa = by_reg; end
            ecsm_pkg::S_RED_A:   begin req.op = ecsm_pkg::OP_RED; req.opa = ca_reg; end
            ecsm_pkg::S_ADD_NUM: begin req.op = ecsm_pkg::OP_SUB;
                                       req.opa = by_reg; req.opb = ay_reg; end
            ecsm_pkg::S_ADD_DEN: begin req.op = ecsm_pkg::OP_SUB;
                                       req.opa = bx_reg; req.opb = ax_reg; end
            ecsm_pkg::S_DBL_SQ:  begin req.opa = px_reg; req.opb = px_reg; end
            ecsm_pkg::S_DBL_SQ3: begin req.opa = tmp_reg; req.opb = W'(3); end
            ecsm_pkg::S_DBL_NUM: begin req.op = ecsm_pkg::OP_ADD;
                                       req.opa = tmp_reg; req.opb = ca_reg; end
            ecsm_pkg::S_DBL_DEN: begin req.opa = py_reg; req.opb = W'(2); end
            ecsm_pkg::S_INV:     begin req.op = ecsm_pkg::OP_INV; req.opa = tmp_reg; end
            ecsm_pkg::S_LAM:     begin req.opa = num_reg; req.opb = tmp_reg; end
            ecsm_pkg::S_LSQ:     begin req.opa = lam_reg; req.opb = lam_reg; end
            ecsm_pkg::S_RX1:     begin req.op = ecsm_pkg::OP_SUB;
                                       req.opa = tmp_reg; req.opb = px_reg; end
            ecsm_pkg::S_RX2:     begin req.op = ecsm_pkg::OP_SUB;
                                       req.opa = tmp_reg; req.opb = qx_reg; end
            ecsm_pkg::S_DX:      begin req.op = ecsm_pkg::OP_SUB;
                                       req.opa = px_reg; req.opb = nx_reg; end
            ecsm_pkg::S_LDX:     begin req.opa = lam_reg; req.opb = tmp_reg; end
            ecsm_pkg::S_RY:      begin req.op = ecsm_pkg::OP_SUB;
                                       req.opa = tmp_reg; req.opb = py_reg; end
            default:             begin req.op = ecsm_pkg::OP_MUL; end
        endcase
    end

    // result outputs
    always_comb
    begin
        done     = (state_reg == ecsm_pkg::S_DONE);
        res_fail = fail_reg;
        res_inf  = !fail_reg && ainf_reg;
        res_x    = (fail_reg || ainf_reg) ? '0 : 16'(ax_reg);
        res_y    = (fail_reg || ainf_reg) ? '0 : 16'(ay_reg);
    end

endmodule

// File: rtl/ecsm_checker.sv
// ecsm_checker: port-level checks on the scalar multiply unit, bound to the top
// depends on ec_scalar_multiply_gfp_unit ports only
module ecsm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] result_x,
    input logic [15:0] result_y,
    input logic        result_is_infinity,
    input logic        inverse_failed
);

    // an infinity result carries zero coordinates
    a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_is_infinity |-> result_x == '0 && result_y == '0)
        else $error("infinity with nonzero coordinates");

    // failure excludes infinity
    a_fail_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && inverse_failed |-> !result_is_infinity)
        else $error("failure and infinity both set");

    // a held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_x) && $stable(result_y))
        else $error("stalled result changed");

    // no new item while a result waits
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

endmodule

bind ec_scalar_multiply_gfp_unit ecsm_checker u_ecsm_checker (.*);
